/* hdl/srm_pkg.sv */
// ---------------------------------------------------------------------------
// srm_pkg: shared types and constants of the stable roommates matcher
// Holds the agent count, the field widths and the structs that pass
// between the top level and the matching core.
// ---------------------------------------------------------------------------
`default_nettype none

package srm_pkg;

  // Largest number of agents the preference table holds.
  localparam int MaxAgents = 32;
  // Width of an agent number or a rank position.
  localparam int AgW = $clog2(MaxAgents);
  // Width of a count that can hold MaxAgents itself.
  localparam int CntW = AgW + 1;
  // Width of a table address made of an agent and a rank.
  localparam int TabW = 2 * AgW;
  // Marker for "no agent" in the proposal bookkeeping.
  localparam logic [CntW-1:0] None = {CntW{1'b1}};

  // Status codes of a result item.
  localparam logic StatMatched  = 1'b0;
  localparam logic StatNoStable = 1'b1;

  // Input command handed to the core.
  typedef struct packed {
    logic           ld_we;
    logic           run;
    logic [AgW-1:0] agent;
    logic [AgW-1:0] rank;
    logic [AgW-1:0] partner;
  } cmd_t;

  // Result item offered by the core.
  typedef struct packed {
    logic           vld;
    logic [AgW-1:0] agent;
    logic [AgW-1:0] partner;
    logic           status;
    logic           last;
  } res_t;

endpackage

`default_nettype wire

/* hdl/srm_core.sv */
// ---------------------------------------------------------------------------
// srm_core: sequencer of the stable roommates matcher
// Holds the preference, rank and removal tables and walks the proposal
// phase, the trim, and the rotation eliminations one table access at a time.
// ---------------------------------------------------------------------------
`default_nettype none

module srm_core import srm_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cmd_t            cmd_i,
  input  wire logic [CntW-1:0] n_agents_i,
  input  wire logic            res_ack_i,
  output logic                 busy_o,
  output res_t                 res_o
);

  typedef enum logic [5:0] {
    S_IDLE, S_CLR, S_VRD, S_VCHK,
    S_P1SCAN, S_P1Q, S_P1OP, S_P1OPC, S_P1DEC,
    S_TRROW, S_TRRD, S_TRCHK, S_TRDEC, S_AE,
    S_ROSCAN, S_ER_TAIL, S_ER_X, S_ER_P2, S_ER_SRD, S_ER_SCHK, S_ER_PUSH,
    S_EL_I, S_EL_RD1, S_EL_RD2, S_EL_LL, S_EL_CHK,
    S_OUT_SC, S_OUT_PUT, S_FAIL,
    S_RP0, S_RP1, S_RP2, S_SC_RD, S_SC_CHK
  } st_e;

  localparam int Depth = MaxAgents * MaxAgents;
  localparam int RotW  = $clog2(MaxAgents + 1);

  // Tables.
  logic [AgW-1:0]   pref_mem [Depth];
  logic [AgW-1:0]   rank_mem [Depth];
  logic             rem_mem  [Depth];
  logic [2*AgW-1:0] rot_mem  [MaxAgents+1];

  logic [AgW-1:0]   pref_rd_q, rank_rd_q;
  logic             rem_rd_q;
  logic [2*AgW-1:0] rot_rd_q;

  // Per-agent bookkeeping.
  logic [CntW-1:0] prop_q [MaxAgents];
  logic [CntW-1:0] held_q [MaxAgents];
  logic [CntW-1:0] next_q [MaxAgents];
  logic [AgW-1:0]  tail_q [MaxAgents];

  st_e             state_q, rp_ret_q, sc_ret_q;
  logic [CntW-1:0] nn_q, n_q, idx_q, h_q;
  logic [TabW-1:0] clr_q;
  logic [MaxAgents-1:0] seen_q;
  logic            moved_q, settled_q, ae_final_q, found_q, rm_any_q;
  logic [AgW-1:0]  q_q, op_q, opc_q;
  logic [CntW-1:0] cur_q;
  logic [AgW-1:0]  rp_a_q, rp_b_q, rp_rank_q;
  logic            rp_pass_q;
  logic [AgW-1:0]  sc_a_q;
  logic [CntW-1:0] sc_idx_q, sc_val_q;
  logic            sc_up_q, sc_k_q, sc_seen_q;
  logic [AgW-1:0]  p_q, x_q, p2_q, keep_q;
  logic [RotW-1:0] len_q, j_q, rt_q, i_q;

  logic [AgW-1:0]  m;
  logic [CntW-1:0] nn_run, nn_m1, sc_pos;
  logic            v_bad;

  logic [TabW-1:0] pref_ra, rank_ra, rem_ra, rank_wa, rem_wa;
  logic            rank_we, rem_we, rem_wd;
  logic [RotW-1:0] rot_ra;

  assign m     = n_q[AgW-1:0];
  assign nn_m1 = nn_q - CntW'(1);
  assign sc_pos = sc_up_q ? sc_idx_q : sc_idx_q - CntW'(1);

  // Agent count saturated to the supported range at run start.
  always_comb begin
    nn_run = n_agents_i;
    if (n_agents_i < CntW'(2)) nn_run = CntW'(2);
    if (n_agents_i > CntW'(MaxAgents)) nn_run = CntW'(MaxAgents);
  end

  // A list entry that is out of range, names its owner or repeats.
  assign v_bad = ({1'b0, pref_rd_q} >= nn_q) || (pref_rd_q == m) || seen_q[pref_rd_q];

  // Table address and write selection for the current step.
  always_comb begin
    pref_ra = {m, idx_q[AgW-1:0]};
    rank_ra = {rp_a_q, rp_b_q};
    rem_ra  = {sc_a_q, sc_pos[AgW-1:0]};
    rot_ra  = j_q;
    rank_we = 1'b0;
    rank_wa = {m, pref_rd_q};
    rem_we  = 1'b0;
    rem_wa  = clr_q;
    rem_wd  = 1'b0;
    case (state_q)
      S_P1SCAN: pref_ra = {m, next_q[m][AgW-1:0]};
      S_TRRD:   pref_ra = {m, idx_q[AgW-1:0] - AgW'(1)};
      S_SC_RD:  pref_ra = {sc_a_q, sc_pos[AgW-1:0]};
      S_P1Q:    rank_ra = {pref_rd_q, m};
      S_P1OP:   rank_ra = {q_q, held_q[q_q][AgW-1:0]};
      S_RP1:    rem_ra  = {rp_a_q, rank_rd_q};
      S_EL_I:   rot_ra  = i_q;
      S_EL_RD1: rot_ra  = i_q - RotW'(1);
      S_VCHK:   rank_we = !v_bad;
      S_CLR:    rem_we  = 1'b1;
      S_RP2: begin
        rem_we = !rem_rd_q;
        rem_wa = {rp_a_q, rp_rank_q};
        rem_wd = 1'b1;
      end
      default: ;
    endcase
  end

  // Preference table: written by load items.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_we) pref_mem[{cmd_i.agent, cmd_i.rank}] <= cmd_i.partner;
    pref_rd_q <= pref_mem[pref_ra];
  end

  // Rank table: position of each partner in an agent's list.
  always_ff @(posedge clk_i) begin
    if (rank_we) rank_mem[rank_wa] <= idx_q[AgW-1:0];
    rank_rd_q <= rank_mem[rank_ra];
  end

  // Removal marks, cleared by a sweep at the start of every run.
  always_ff @(posedge clk_i) begin
    if (rem_we) rem_mem[rem_wa] <= rem_wd;
    rem_rd_q <= rem_mem[rem_ra];
  end

  // Rotation buffer: pairs of (next agent, the second choice whose last entry it is).
  always_ff @(posedge clk_i) begin
    if (state_q == S_ER_PUSH) rot_mem[len_q] <= {p2_q, x_q};
    rot_rd_q <= rot_mem[rot_ra];
  end

  // Main sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rp_ret_q   <= S_IDLE;
      sc_ret_q   <= S_IDLE;
      nn_q       <= CntW'(2);
      n_q        <= '0;
      idx_q      <= '0;
      h_q        <= '0;
      clr_q      <= '0;
      seen_q     <= '0;
      moved_q    <= 1'b0;
      settled_q  <= 1'b0;
      ae_final_q <= 1'b0;
      found_q    <= 1'b0;
      rm_any_q   <= 1'b0;
      q_q        <= '0;
      op_q       <= '0;
      opc_q      <= '0;
      cur_q      <= '0;
      rp_a_q     <= '0;
      rp_b_q     <= '0;
      rp_rank_q  <= '0;
      rp_pass_q  <= 1'b0;
      sc_a_q     <= '0;
      sc_idx_q   <= '0;
      sc_val_q   <= '0;
      sc_up_q    <= 1'b0;
      sc_k_q     <= 1'b0;
      sc_seen_q  <= 1'b0;
      p_q        <= '0;
      x_q        <= '0;
      p2_q       <= '0;
      keep_q     <= '0;
      len_q      <= '0;
      j_q        <= '0;
      rt_q       <= '0;
      i_q        <= '0;
      for (int k = 0; k < MaxAgents; k++) begin
        prop_q[k] <= None;
        held_q[k] <= None;
        next_q[k] <= '0;
        tail_q[k] <= '0;
      end
    end else begin
      case (state_q)
        // Wait for a run item; start the clearing sweep.
        S_IDLE: begin
          if (cmd_i.run) begin
            nn_q  <= nn_run;
            clr_q <= '0;
            for (int k = 0; k < MaxAgents; k++) begin
              prop_q[k] <= None;
              held_q[k] <= None;
              next_q[k] <= '0;
              tail_q[k] <= nn_run[AgW-1:0] - AgW'(1);
            end
            state_q <= S_CLR;
          end
        end
        S_CLR: begin
          clr_q <= clr_q + TabW'(1);
          if (clr_q == {TabW{1'b1}}) begin
            n_q     <= '0;
            idx_q   <= '0;
            seen_q  <= '0;
            state_q <= S_VRD;
          end
        end
        // List check, which also fills the rank table.
        S_VRD: begin
          if (n_q == nn_q) begin
            n_q     <= '0;
            moved_q <= 1'b0;
            state_q <= S_P1SCAN;
          end else if (idx_q == nn_m1) begin
            n_q    <= n_q + CntW'(1);
            idx_q  <= '0;
            seen_q <= '0;
          end else begin
            state_q <= S_VCHK;
          end
        end
        S_VCHK: begin
          if (v_bad) begin
            state_q <= S_FAIL;
          end else begin
            seen_q[pref_rd_q] <= 1'b1;
            idx_q   <= idx_q + CntW'(1);
            state_q <= S_VRD;
          end
        end
        // Proposal rounds.
        S_P1SCAN: begin
          if (n_q == nn_q) begin
            n_q <= '0;
            if (moved_q) begin
              moved_q <= 1'b0;
            end else begin
              state_q <= S_TRROW;
            end
          end else if (prop_q[m] != None) begin
            n_q <= n_q + CntW'(1);
          end else if (next_q[m] >= nn_m1) begin
            state_q <= S_FAIL;
          end else begin
            state_q <= S_P1Q;
          end
        end
        S_P1Q: begin
          q_q     <= pref_rd_q;
          state_q <= S_P1OP;
        end
        S_P1OP: begin
          op_q  <= rank_rd_q;
          cur_q <= held_q[q_q];
          if (held_q[q_q] == None) begin
            opc_q   <= nn_m1[AgW-1:0];
            state_q <= S_P1DEC;
          end else begin
            state_q <= S_P1OPC;
          end
        end
        S_P1OPC: begin
          opc_q   <= rank_rd_q;
          state_q <= S_P1DEC;
        end
        S_P1DEC: begin
          if (op_q < opc_q) begin
            if (cur_q != None) prop_q[cur_q[AgW-1:0]] <= None;
            prop_q[m]   <= {1'b0, q_q};
            held_q[q_q] <= n_q;
          end
          next_q[m] <= next_q[m] + CntW'(1);
          moved_q   <= 1'b1;
          n_q       <= n_q + CntW'(1);
          state_q   <= S_P1SCAN;
        end
        // Trim every list below the proposal it holds.
        S_TRROW: begin
          if (n_q == nn_q) begin
            idx_q      <= '0;
            ae_final_q <= 1'b0;
            state_q    <= S_AE;
          end else begin
            h_q     <= held_q[m];
            idx_q   <= nn_m1;
            state_q <= S_TRRD;
          end
        end
        S_TRRD: begin
          if (idx_q == '0) begin
            n_q     <= n_q + CntW'(1);
            state_q <= S_TRROW;
          end else begin
            state_q <= S_TRCHK;
          end
        end
        S_TRCHK: begin
          if ({1'b0, pref_rd_q} == h_q) begin
            n_q     <= n_q + CntW'(1);
            state_q <= S_TRROW;
          end else begin
            rp_a_q    <= m;
            rp_b_q    <= pref_rd_q;
            rp_pass_q <= 1'b0;
            rp_ret_q  <= S_TRDEC;
            state_q   <= S_RP0;
          end
        end
        S_TRDEC: begin
          idx_q   <= idx_q - CntW'(1);
          state_q <= S_TRRD;
        end
        // Check for an empty list, one agent a cycle.
        S_AE: begin
          if (idx_q == nn_q) begin
            n_q       <= '0;
            settled_q <= 1'b1;
            state_q   <= ae_final_q ? S_OUT_SC : S_ROSCAN;
          end else if (tail_q[idx_q[AgW-1:0]] == '0) begin
            state_q <= S_FAIL;
          end else begin
            idx_q <= idx_q + CntW'(1);
          end
        end
        // Sweep agents and eliminate rotations until all lists are single.
        S_ROSCAN: begin
          if (n_q == nn_q) begin
            n_q <= '0;
            if (settled_q) begin
              idx_q      <= '0;
              ae_final_q <= 1'b1;
              state_q    <= S_AE;
            end else begin
              settled_q <= 1'b1;
            end
          end else if (tail_q[m] > AgW'(1)) begin
            settled_q <= 1'b0;
            p_q       <= m;
            len_q     <= '0;
            state_q   <= S_ER_TAIL;
          end else begin
            n_q <= n_q + CntW'(1);
          end
        end
        S_ER_TAIL: begin
          if (tail_q[p_q] < AgW'(2)) begin
            state_q <= S_FAIL;
          end else begin
            sc_a_q    <= p_q;
            sc_up_q   <= 1'b1;
            sc_k_q    <= 1'b1;
            sc_seen_q <= 1'b0;
            sc_idx_q  <= '0;
            sc_ret_q  <= S_ER_X;
            state_q   <= S_SC_RD;
          end
        end
        S_ER_X: begin
          if (sc_val_q == None) begin
            state_q <= S_FAIL;
          end else begin
            x_q       <= sc_val_q[AgW-1:0];
            sc_a_q    <= sc_val_q[AgW-1:0];
            sc_up_q   <= 1'b0;
            sc_k_q    <= 1'b0;
            sc_seen_q <= 1'b0;
            sc_idx_q  <= nn_m1;
            sc_ret_q  <= S_ER_P2;
            state_q   <= S_SC_RD;
          end
        end
        S_ER_P2: begin
          if (sc_val_q == None) begin
            state_q <= S_FAIL;
          end else begin
            p2_q    <= sc_val_q[AgW-1:0];
            j_q     <= '0;
            state_q <= S_ER_SRD;
          end
        end
        S_ER_SRD: begin
          if (j_q == len_q) begin
            found_q <= 1'b0;
            state_q <= S_ER_PUSH;
          end else begin
            state_q <= S_ER_SCHK;
          end
        end
        S_ER_SCHK: begin
          if (rot_rd_q[2*AgW-1:AgW] == p2_q) begin
            rt_q    <= j_q;
            found_q <= 1'b1;
            state_q <= S_ER_PUSH;
          end else begin
            j_q     <= j_q + RotW'(1);
            state_q <= S_ER_SRD;
          end
        end
        S_ER_PUSH: begin
          len_q <= len_q + RotW'(1);
          if (found_q) begin
            i_q      <= rt_q + RotW'(1);
            rm_any_q <= 1'b0;
            state_q  <= S_EL_I;
          end else begin
            p_q     <= p2_q;
            state_q <= S_ER_TAIL;
          end
        end
        // Eliminate the rotation that was found.
        S_EL_I: begin
          if (i_q == len_q) begin
            if (rm_any_q) begin
              n_q     <= n_q + CntW'(1);
              state_q <= S_ROSCAN;
            end else begin
              state_q <= S_FAIL;
            end
          end else begin
            state_q <= S_EL_RD1;
          end
        end
        S_EL_RD1: begin
          x_q     <= rot_rd_q[AgW-1:0];
          state_q <= S_EL_RD2;
        end
        S_EL_RD2: begin
          keep_q  <= rot_rd_q[2*AgW-1:AgW];
          state_q <= S_EL_LL;
        end
        S_EL_LL: begin
          sc_a_q    <= x_q;
          sc_up_q   <= 1'b0;
          sc_k_q    <= 1'b0;
          sc_seen_q <= 1'b0;
          sc_idx_q  <= nn_m1;
          sc_ret_q  <= S_EL_CHK;
          state_q   <= S_SC_RD;
        end
        S_EL_CHK: begin
          if (sc_val_q == None) begin
            state_q <= S_FAIL;
          end else if (sc_val_q[AgW-1:0] == keep_q) begin
            i_q     <= i_q + RotW'(1);
            state_q <= S_EL_I;
          end else begin
            rp_a_q    <= x_q;
            rp_b_q    <= sc_val_q[AgW-1:0];
            rp_pass_q <= 1'b0;
            rp_ret_q  <= S_EL_LL;
            state_q   <= S_RP0;
          end
        end
        // Result items, one per agent.
        S_OUT_SC: begin
          if (n_q == nn_q) begin
            state_q <= S_IDLE;
          end else begin
            sc_a_q    <= m;
            sc_up_q   <= 1'b1;
            sc_k_q    <= 1'b0;
            sc_seen_q <= 1'b0;
            sc_idx_q  <= '0;
            sc_ret_q  <= S_OUT_PUT;
            state_q   <= S_SC_RD;
          end
        end
        S_OUT_PUT: begin
          if (res_ack_i) begin
            n_q     <= n_q + CntW'(1);
            state_q <= S_OUT_SC;
          end
        end
        S_FAIL: begin
          if (res_ack_i) state_q <= S_IDLE;
        end
        // Remove a pair from both lists.
        S_RP0: begin
          if ({1'b0, rp_a_q} >= nn_q || {1'b0, rp_b_q} >= nn_q) begin
            state_q <= rp_ret_q;
          end else begin
            state_q <= S_RP1;
          end
        end
        S_RP1: begin
          rp_rank_q <= rank_rd_q;
          state_q   <= S_RP2;
        end
        S_RP2: begin
          if (!rem_rd_q) begin
            rm_any_q <= 1'b1;
            if (tail_q[rp_a_q] != '0) tail_q[rp_a_q] <= tail_q[rp_a_q] - AgW'(1);
          end
          if (rp_pass_q) begin
            state_q <= rp_ret_q;
          end else begin
            rp_a_q    <= rp_b_q;
            rp_b_q    <= rp_a_q;
            rp_pass_q <= 1'b1;
            state_q   <= S_RP0;
          end
        end
        // Find the first or second live entry, or the last one.
        S_SC_RD: begin
          if (sc_up_q ? (sc_idx_q == nn_m1) : (sc_idx_q == '0)) begin
            sc_val_q <= None;
            state_q  <= sc_ret_q;
          end else begin
            state_q <= S_SC_CHK;
          end
        end
        S_SC_CHK: begin
          if (!rem_rd_q && sc_seen_q == sc_k_q) begin
            sc_val_q <= {1'b0, pref_rd_q};
            state_q  <= sc_ret_q;
          end else begin
            if (!rem_rd_q) sc_seen_q <= 1'b1;
            sc_idx_q <= sc_up_q ? sc_idx_q + CntW'(1) : sc_idx_q - CntW'(1);
            state_q  <= S_SC_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Result offer and busy flag.
  always_comb begin
    res_o         = '0;
    res_o.vld     = (state_q == S_OUT_PUT) || (state_q == S_FAIL);
    res_o.status  = StatMatched;
    if (state_q == S_FAIL) begin
      res_o.status = StatNoStable;
      res_o.last   = 1'b1;
    end else begin
      res_o.agent   = m;
      res_o.partner = sc_val_q[AgW-1:0];
      res_o.last    = (n_q + CntW'(1)) == nn_q;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // The clearing sweep runs to its end before the list check.
  a_clr_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR |=> state_q == S_CLR || state_q == S_VRD)
    else $error("clearing sweep left early");

  // A run always works on a saturated agent count.
  a_nn_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> nn_q >= CntW'(2) && nn_q <= CntW'(MaxAgents))
    else $error("agent count out of range");

  // A settled matching leaves every agent with a partner.
  a_partner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT_PUT |-> sc_val_q != None)
    else $error("matched agent without partner");

  // A failure item ends the run.
  a_fail_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FAIL && res_ack_i |=> state_q == S_IDLE)
    else $error("run continued after failure item");

endmodule

`default_nettype wire

/* hdl/stable_roommates_matcher_unit.sv */
// ---------------------------------------------------------------------------
// stable_roommates_matcher_unit: stable roommates matching engine
// Loads preference entries and, on a run item, computes a stable matching
// or reports that none exists.
// ---------------------------------------------------------------------------
// A load item gives no result. A run item first clears the 1024-entry
// removal table, then walks the algorithm one table access at a time.
// Items are taken only while idle; in_stall_o stays high for the whole run.
// Reset clears the sequencer and sets n_agents to 32; the preference and rank
// tables hold no value until written.
`default_nettype none

module stable_roommates_matcher_unit import srm_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_wr_en_i,
  input  wire logic [CntW-1:0] cfg_wr_data_i,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic            mode_i,
  input  wire logic [AgW-1:0]  agent_i,
  input  wire logic [AgW-1:0]  rank_i,
  input  wire logic [AgW-1:0]  pref_partner_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [AgW-1:0]       out_agent_o,
  output logic [AgW-1:0]       out_partner_o,
  output logic                 status_o,
  output logic                 last_o
);

  logic [CntW-1:0] n_agents_q;
  logic            busy;
  logic            in_acc, res_ack;
  cmd_t            cmd;
  res_t            res;
  logic            out_valid_q;
  logic [AgW-1:0]  out_agent_q, out_partner_q;
  logic            status_q, last_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_agents_q <= CntW'(MaxAgents);
    end else if (cfg_wr_en_i) begin
      n_agents_q <= cfg_wr_data_i;
    end
  end

  // Input item decode.
  assign in_stall_o  = busy;
  assign in_acc      = in_valid_i && !busy;
  assign cmd.ld_we   = in_acc && !mode_i;
  assign cmd.run     = in_acc && mode_i;
  assign cmd.agent   = agent_i;
  assign cmd.rank    = rank_i;
  assign cmd.partner = pref_partner_i;

  srm_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .n_agents_i (n_agents_q),
    .res_ack_i  (res_ack),
    .busy_o     (busy),
    .res_o      (res)
  );

  // Output register: takes a result item when empty or being drained.
  assign res_ack = res.vld && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ack) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack) begin
      out_agent_q   <= res.agent;
      out_partner_q <= res.partner;
      status_q      <= res.status;
      last_q        <= res.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_agent_o   = out_agent_q;
  assign out_partner_o = out_partner_q;
  assign status_o      = status_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

/* tb/srm_match_checker.sv */
// ---------------------------------------------------------------------------
// srm_match_checker: scoreboard for the stable roommates matcher
// Watches the configuration port and both item channels, keeps its own copy
// of the preference table, solves each run with Irving's algorithm and
// compares every result item with the oldest predicted one.
// ---------------------------------------------------------------------------
module srm_match_checker import srm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_wr_en_i,
  input  logic [CntW-1:0] cfg_wr_data_i,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  logic            mode_i,
  input  logic [AgW-1:0]  agent_i,
  input  logic [AgW-1:0]  rank_i,
  input  logic [AgW-1:0]  pref_partner_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  logic [AgW-1:0]  out_agent_i,
  input  logic [AgW-1:0]  out_partner_i,
  input  logic            status_i,
  input  logic            last_i,
  output int              err_count_o,
  output int              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NoAgent = 255;

  typedef struct packed {
    logic [AgW-1:0] agent;
    logic [AgW-1:0] partner;
    logic           status;
    logic           last;
  } pairing_t;

  pairing_t pairings_q[$];

  // Shadow of the block's tables and bookkeeping.
  logic [AgW-1:0] pref_tab[MaxAgents*MaxAgents];
  logic [AgW-1:0] rank_tab[MaxAgents*MaxAgents];
  bit             gone[MaxAgents*MaxAgents];
  int             prop_to[MaxAgents];
  int             held_by[MaxAgents];
  int             next_pick[MaxAgents];
  int             live_cnt[MaxAgents];
  int             rot_p[MaxAgents+1];
  int             rot_x[MaxAgents+1];
  logic [CntW-1:0] n_cfg = 6'd32;
  int             nn;
  int             errs = 0;

  assign err_count_o = errs;
  assign pending_o   = pairings_q.size();

  // Entry k among the live entries of a list.
  function automatic int live_at(int a, int k);
    int seen;
    seen = 0;
    for (int r = 0; r + 1 < nn; r++) begin
      if (!gone[a*MaxAgents+r]) begin
        if (seen == k) return pref_tab[a*MaxAgents+r];
        seen++;
      end
    end
    return NoAgent;
  endfunction

  function automatic int live_tail(int a);
    for (int r = nn - 1; r > 0; r--) begin
      if (!gone[a*MaxAgents+r-1]) return pref_tab[a*MaxAgents+r-1];
    end
    return NoAgent;
  endfunction

  function automatic int drop_entry(int a, int b);
    int s;
    s = a * MaxAgents + rank_tab[a*MaxAgents+b];
    if (gone[s]) return 0;
    gone[s] = 1;
    if (live_cnt[a] > 0) live_cnt[a]--;
    return 1;
  endfunction

  function automatic int drop_pair(int a, int b);
    if (a >= nn || b >= nn) return 0;
    return drop_entry(a, b) + drop_entry(b, a);
  endfunction

  // Checks each list and fills the rank lookup.
  function automatic bit lists_ok();
    bit [31:0] seen;
    int p;
    for (int a = 0; a < nn; a++) begin
      seen = '0;
      for (int r = 0; r + 1 < nn; r++) begin
        p = pref_tab[a*MaxAgents+r];
        if (p >= nn || p == a || seen[p]) return 0;
        seen[p] = 1'b1;
        rank_tab[a*MaxAgents+p] = r[AgW-1:0];
      end
    end
    return 1;
  endfunction

  // Proposal rounds.
  function automatic bit propose_all();
    bit moved;
    int q, cur, op, opc;
    moved = 1;
    while (moved) begin
      moved = 0;
      for (int n = 0; n < nn; n++) begin
        if (prop_to[n] != NoAgent) continue;
        if (next_pick[n] >= nn - 1) return 0;
        q   = pref_tab[n*MaxAgents+next_pick[n]];
        op  = rank_tab[q*MaxAgents+n];
        cur = held_by[q];
        // A proposee holding nobody gives the empty hold a rank below every list entry.
        opc = (cur == NoAgent) ? nn - 1 : rank_tab[q*MaxAgents+cur];
        if (op < opc) begin
          prop_to[n] = q;
          if (cur != NoAgent) prop_to[cur] = NoAgent;
          held_by[q] = n;
        end
        next_pick[n]++;
        moved = 1;
      end
    end
    return 1;
  endfunction

  function automatic bit any_empty();
    for (int n = 0; n < nn; n++) if (live_cnt[n] == 0) return 1;
    return 0;
  endfunction

  // Finds the rotation reached from start and eliminates it.
  function automatic bit drop_rotation(int start);
    int len, rt, p, x, p2, keep, l, removed;
    bit found;
    len = 0; rt = 0; p = start; removed = 0;
    forever begin
      found = 0;
      if (live_cnt[p] < 2) return 0;
      x = live_at(p, 1);
      if (x == NoAgent) return 0;
      p2 = live_tail(x);
      if (p2 == NoAgent) return 0;
      for (int j = 0; j < len; j++) begin
        if (rot_p[j] == p2) begin
          rt = j; found = 1; break;
        end
      end
      if (len > MaxAgents) return 0;
      rot_p[len] = p2;
      rot_x[len] = x;
      len++;
      if (found) break;
      p = p2;
    end
    for (int i = rt + 1; i < len; i++) begin
      x = rot_x[i];
      keep = rot_p[i-1];
      forever begin
        l = live_tail(x);
        if (l == NoAgent) return 0;
        if (l == keep) break;
        removed += drop_pair(x, l);
      end
    end
    return removed != 0;
  endfunction

  function automatic bit solve_roommates();
    int h, v;
    bit settled;
    foreach (gone[i]) gone[i] = 0;
    for (int n = 0; n < nn; n++) begin
      prop_to[n] = NoAgent;
      held_by[n] = NoAgent;
      next_pick[n] = 0;
      live_cnt[n] = nn - 1;
    end
    if (!lists_ok()) return 0;
    if (!propose_all()) return 0;
    // Trim every list to the proposal it holds.
    for (int n = 0; n < nn; n++) begin
      h = held_by[n];
      for (int r = nn - 1; r > 0; r--) begin
        v = pref_tab[n*MaxAgents+r-1];
        if (v == h) break;
        void'(drop_pair(n, v));
      end
    end
    if (any_empty()) return 0;
    settled = 0;
    while (!settled) begin
      settled = 1;
      for (int n = 0; n < nn; n++) begin
        if (live_cnt[n] > 1) begin
          settled = 0;
          if (!drop_rotation(n)) return 0;
        end
      end
    end
    return !any_empty();
  endfunction

  // Channel monitor: input side first, then result side. A count written at
  // the same edge as a run item takes effect only for later runs.
  always @(posedge clk_i) begin
    pairing_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        if (!mode_i) begin
          pref_tab[agent_i*MaxAgents+rank_i] = pref_partner_i;
        end else begin
          nn = n_cfg;
          if (nn < 2) nn = 2;
          if (nn > MaxAgents) nn = MaxAgents;
          if (!solve_roommates()) begin
            want = '{agent: '0, partner: '0, status: StatNoStable, last: 1'b1};
            pairings_q.insert(pairings_q.size(), want);
          end else begin
            for (int n = 0; n < nn; n++) begin
              want.agent   = n[AgW-1:0];
              want.partner = AgW'(live_at(n, 0));
              want.status  = StatMatched;
              want.last    = (n + 1 == nn);
              pairings_q.insert(pairings_q.size(), want);
            end
          end
        end
      end
      if (cfg_wr_en_i) n_cfg = cfg_wr_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (pairings_q.size() == 0) begin
          $error("result item with no prediction waiting");
          errs++;
        end else begin
          want = pairings_q.pop_front();
          if (out_agent_i !== want.agent) begin
            $error("out_agent: expected %0d, actual %0d", want.agent, out_agent_i);
            errs++;
          end
          if (out_partner_i !== want.partner) begin
            $error("out_partner: expected %0d, actual %0d", want.partner, out_partner_i);
            errs++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            errs++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last_i);
            errs++;
          end
        end
      end
    end
  end

endmodule

/* tb/tb_stable_roommates_matcher_unit.sv */
// ---------------------------------------------------------------------------
// tb_stable_roommates_matcher_unit: stimulus and verdict for the matcher
// Loads preference lists, changes the agent count between runs and starts
// runs, with random gaps on the input and random stalls on the output.
// The checker beside the block predicts and compares every result item.
// ---------------------------------------------------------------------------
module tb_stable_roommates_matcher_unit import srm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 6000000;
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeRun  = 1'b1;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_wr_en_i = 1'b0;
  logic [CntW-1:0] cfg_wr_data_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic            mode_i = 1'b0;
  logic [AgW-1:0]  agent_i = '0;
  logic [AgW-1:0]  rank_i = '0;
  logic [AgW-1:0]  pref_partner_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [AgW-1:0]  out_agent_o;
  logic [AgW-1:0]  out_partner_o;
  logic            status_o;
  logic            last_o;
  int              err_count;
  int              pending;
  int              cycles = 0;
  bit              calm = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  stable_roommates_matcher_unit DUT (.*);

  srm_match_checker checker_i (
    .clk_i, .rst_ni, .cfg_wr_en_i, .cfg_wr_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .mode_i, .agent_i, .rank_i, .pref_partner_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_agent_i(out_agent_o),
    .out_partner_i(out_partner_o), .status_i(status_o), .last_i(last_o),
    .err_count_o(err_count), .pending_o(pending)
  );

  // Run guard.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Random length of an idle stretch: mostly short, a few long.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(99, 0);
    if (calm || pick < 60) return 0;
    if (pick < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Result side stalls.
  always begin
    int hold;
    @(negedge clk_i);
    if (!calm && $urandom_range(3, 0) == 0) begin
      out_stall_i = 1'b1;
      hold = idle_len();
    end else begin
      out_stall_i = 1'b0;
      hold = $urandom_range(6, 0);
    end
    repeat (hold) @(negedge clk_i);
  end

  task automatic send_item(logic m, int a, int r, int p);
    int gap;
    gap = idle_len();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    mode_i = m;
    agent_i = a[AgW-1:0];
    rank_i = r[AgW-1:0];
    pref_partner_i = p[AgW-1:0];
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Waits for every predicted result, then lets the block settle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_count(int v);
    @(negedge clk_i);
    cfg_wr_en_i = 1'b1;
    cfg_wr_data_i = v[CntW-1:0];
    @(negedge clk_i);
    cfg_wr_en_i = 1'b0;
  endtask

  // Loads a random well-formed list for each of the first n agents.
  task automatic load_lists(int n);
    int order[$];
    int j, t;
    for (int a = 0; a < n; a++) begin
      order.delete();
      for (int b = 0; b < n; b++) if (b != a) order.insert(order.size(), b);
      for (int i = order.size() - 1; i > 0; i--) begin
        j = $urandom_range(i, 0);
        t = order[i]; order[i] = order[j]; order[j] = t;
      end
      for (int r = 0; r < n - 1; r++) send_item(ModeLoad, a, r, order[r]);
    end
  endtask

  task automatic run_match();
    send_item(ModeRun, $urandom_range(31, 0), $urandom_range(31, 0), $urandom_range(31, 0));
  endtask

  initial begin
    int n, w;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: two and three agents, a malformed list of each kind, count saturation.
    write_count(2);
    send_item(ModeLoad, 31, 31, 31);
    send_item(ModeLoad, 0, 0, 1);
    send_item(ModeLoad, 1, 0, 0);
    run_match();
    send_item(ModeLoad, 0, 0, 0);
    run_match();
    send_item(ModeLoad, 0, 0, 5);
    run_match();
    send_item(ModeLoad, 0, 0, 1);
    drain();
    write_count(0);
    run_match();
    drain();
    write_count(1);
    run_match();
    drain();
    write_count(3);
    send_item(ModeLoad, 0, 0, 1);
    send_item(ModeLoad, 0, 1, 1);
    send_item(ModeLoad, 1, 0, 2);
    send_item(ModeLoad, 1, 1, 0);
    send_item(ModeLoad, 2, 0, 0);
    send_item(ModeLoad, 2, 1, 1);
    run_match();
    send_item(ModeLoad, 0, 1, 2);
    run_match();
    drain();

    // Random: mostly well-formed tables of small size, some broken ones.
    for (int k = 0; k < 5; k++) begin
      calm = ($urandom_range(4, 0) == 0);
      n = $urandom_range(9, 2);
      w = ($urandom_range(7, 0) == 0) ? ((n == 2) ? $urandom_range(1, 0) : n) : n;
      write_count(w);
      load_lists(n);
      if ($urandom_range(3, 0) == 0) begin
        send_item(ModeLoad, $urandom_range(n - 1, 0), $urandom_range(n - 2, 0),
                  $urandom_range(31, 0));
      end
      repeat ($urandom_range(2, 0)) begin
        send_item(ModeLoad, $urandom_range(31, 0), 31, $urandom_range(31, 0));
        send_item(ModeLoad, 31, $urandom_range(31, 0), $urandom_range(31, 0));
      end
      run_match();
      if ($urandom_range(2, 0) == 0) run_match();
      drain();
    end

    // A larger table, run twice with the count written again in between.
    calm = 0;
    write_count(16);
    load_lists(16);
    run_match();
    drain();
    write_count(16);
    run_match();
    drain();

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
